// File: hw/rtl/sorted_key_table_unit_defines.svh
// Assertion macros used by the sorted key table controller.
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKT_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SKT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/skt_pkg.sv
// Types, constants and helpers shared by the sorted key table modules.
package skt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_WIDTH  = 32;
   localparam int UNIT_WIDTH = 32;

   localparam int FIELD_W   = 32;
   localparam int KEY_BITS  = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
   localparam int UNIT_BITS = (UNIT_WIDTH < FIELD_W) ? UNIT_WIDTH : FIELD_W;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   // command codes
   localparam logic [2:0] CMD_ADD        = 3'd0;
   localparam logic [2:0] CMD_REMOVE_AT  = 3'd1;
   localparam logic [2:0] CMD_REMOVE_KEY = 3'd2;
   localparam logic [2:0] CMD_RELEASE    = 3'd3;
   localparam logic [2:0] CMD_FIND       = 3'd4;

   // status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NULL_KEY  = 3'd1;
   localparam logic [2:0] STATUS_RESERVED  = 3'd2;
   localparam logic [2:0] STATUS_NULL_UNIT = 3'd3;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd4;
   localparam logic [2:0] STATUS_RANGE     = 3'd5;
   localparam logic [2:0] STATUS_IN_USE    = 3'd6;
   localparam logic [2:0] STATUS_FULL      = 3'd7;

   // register indexes
   localparam logic REG_NULL_KEY      = 1'b0;
   localparam logic REG_RESERVED_MASK = 1'b1;

   typedef struct packed {
      logic [2:0]         command;
      logic [FIELD_W-1:0] key_id;
      logic [FIELD_W-1:0] unit_ref;
      logic [5:0]         entry_index;
      logic               in_use;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] result_index;
      logic       found;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] null_key;
      logic [FIELD_W-1:0] reserved_flag_mask;
   } cfg_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
   } mem_ctl_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

   // Report a table position in the 6-bit index field.
   function automatic logic [5:0] fit_index(input logic [CNT_W-1:0] pos);
      logic [CNT_W+5:0] wide;
      wide = (CNT_W + 6)'(pos);
      return wide[5:0];
   endfunction

endpackage

// File: hw/rtl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/skt_cmp.sv
// Shared key comparator used by every binary search probe.
module skt_cmp (
   input  logic [skt_pkg::KEY_BITS-1:0] probe_key,
   input  logic [skt_pkg::KEY_BITS-1:0] ref_key,
   output skt_pkg::cmp_type             result
);
   import skt_pkg::*;

   assign result.less  = probe_key < ref_key;
   assign result.equal = probe_key == ref_key;

endmodule

// File: hw/rtl/skt_ctrl.sv
// Command sequencer: validation, binary search, entry shifting and results.
`include "sorted_key_table_unit_defines.svh"

module skt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  skt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output skt_pkg::rsp_type              rsp_data,
   input  skt_pkg::cfg_type              cfg,
   output skt_pkg::mem_ctl_type          mem_ctl,
   output logic [skt_pkg::KEY_BITS-1:0]  key_wr_data,
   output logic [skt_pkg::UNIT_BITS-1:0] unit_wr_data,
   input  logic [skt_pkg::KEY_BITS-1:0]  key_rd_data,
   input  logic [skt_pkg::UNIT_BITS-1:0] unit_rd_data
);
   import skt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_PROBE,
      S_RESOLVE,
      S_SHIFT_UP,
      S_INSERT,
      S_SHIFT_DOWN
   } state_type;

   state_type            state_ff, state_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [UNIT_BITS-1:0] unit_ff, unit_in;
   logic [5:0]           idx_ff, idx_in;
   logic                 in_use_ff, in_use_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic                 hit_ff, hit_in;
   logic [CNT_W-1:0]     src_ff, src_in;
   logic [CNT_W-1:0]     dst_ff, dst_in;
   logic                 pend_ff, pend_in;

   logic                 accept;
   logic [CNT_W:0]       mid_sum;
   logic                 key_is_null;
   logic                 key_reserved;
   logic                 unit_is_null;
   logic                 idx_out_of_range;
   cmp_type              cmp;

   skt_cmp u_cmp (
      .probe_key (key_rd_data),
      .ref_key   (key_ff),
      .result    (cmp)
   );

   assign accept           = start && !busy_ff;
   assign mid_sum          = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign key_is_null      = key_ff == cfg.null_key[KEY_BITS-1:0];
   assign key_reserved     = (key_ff & cfg.reserved_flag_mask[KEY_BITS-1:0]) != '0;
   assign unit_is_null     = unit_ff == '0;
   assign idx_out_of_range = (CNT_W + 6)'(idx_ff) >= (CNT_W + 6)'(count_ff);

   always_comb begin
      logic       done;
      logic [2:0] st;
      logic [5:0] ridx;
      logic       fnd;

      done = 1'b0;
      st   = STATUS_OK;
      ridx = '0;
      fnd  = 1'b0;

      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      unit_in      = unit_ff;
      idx_in       = idx_ff;
      in_use_in    = in_use_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;

      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = dst_ff[IDX_W-1:0];
      mem_ctl.rd_addr = '0;
      key_wr_data     = key_rd_data;
      unit_wr_data    = unit_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.command;
               key_in    = req_data.key_id[KEY_BITS-1:0];
               unit_in   = req_data.unit_ref[UNIT_BITS-1:0];
               idx_in    = req_data.entry_index;
               in_use_in = req_data.in_use;
               busy_in   = 1'b1;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            lo_in  = '0;
            hi_in  = count_ff;
            hit_in = 1'b0;
            unique case (cmd_ff)
               CMD_ADD: begin
                  priority if (key_is_null) begin
                     done = 1'b1;
                     st   = STATUS_NULL_KEY;
                  end else if (key_reserved) begin
                     done = 1'b1;
                     st   = STATUS_RESERVED;
                  end else if (unit_is_null) begin
                     done = 1'b1;
                     st   = STATUS_NULL_UNIT;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               CMD_REMOVE_AT: begin
                  priority if (idx_out_of_range) begin
                     done = 1'b1;
                     st   = STATUS_RANGE;
                  end else if (in_use_ff) begin
                     done = 1'b1;
                     st   = STATUS_IN_USE;
                  end else begin
                     src_in   = CNT_W'(idx_ff) + CNT_ONE;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT_DOWN;
                  end
               end
               CMD_REMOVE_KEY: begin
                  priority if (in_use_ff) begin
                     done = 1'b1;
                     st   = STATUS_IN_USE;
                  end else if (key_is_null) begin
                     done = 1'b1;
                     st   = STATUS_NULL_KEY;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               CMD_RELEASE: begin
                  done = 1'b1;
                  if (count_ff != '0 && in_use_ff) begin
                     st = STATUS_IN_USE;
                  end else begin
                     count_in = '0;
                  end
               end
               CMD_FIND: begin
                  if (key_is_null) begin
                     done = 1'b1;
                     st   = STATUS_NULL_KEY;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end

         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in          = mid_sum[CNT_W:1];
               mem_ctl.rd_addr = mid_sum[IDX_W:1];
               state_in        = S_PROBE;
            end else begin
               state_in = S_RESOLVE;
            end
         end

         S_PROBE: begin
            // probe key is on the RAM output now
            if (cmp.less) begin
               lo_in = mid_ff + CNT_ONE;
            end else begin
               hi_in  = mid_ff;
               hit_in = hit_ff || cmp.equal;
            end
            state_in = S_SEARCH;
         end

         S_RESOLVE: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  priority if (hit_ff) begin
                     done = 1'b1;
                     st   = STATUS_DUPLICATE;
                  end else if (count_ff >= CNT_DEPTH) begin
                     done = 1'b1;
                     st   = STATUS_FULL;
                  end else begin
                     src_in   = count_ff;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT_UP;
                  end
               end
               CMD_REMOVE_KEY: begin
                  if (hit_ff) begin
                     src_in   = lo_ff + CNT_ONE;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT_DOWN;
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  // find
                  done = 1'b1;
                  fnd  = hit_ff;
                  ridx = hit_ff ? fit_index(lo_ff) : '0;
               end
            endcase
         end

         S_SHIFT_UP: begin
            // write back the entry read last beat one slot higher
            mem_ctl.wr_en = pend_ff;
            if (src_ff > lo_ff) begin
               mem_ctl.rd_addr = src_ff[IDX_W-1:0] - IDX_W'(1);
               dst_in          = src_ff;
               src_in          = src_ff - CNT_ONE;
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INSERT;
            end
         end

         S_INSERT: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = lo_ff[IDX_W-1:0];
            key_wr_data     = key_ff;
            unit_wr_data    = unit_ff;
            count_in        = count_ff + CNT_ONE;
            done            = 1'b1;
            ridx            = fit_index(lo_ff);
         end

         S_SHIFT_DOWN: begin
            // write back the entry read last beat one slot lower
            mem_ctl.wr_en = pend_ff;
            if (src_ff < count_ff) begin
               mem_ctl.rd_addr = src_ff[IDX_W-1:0];
               dst_in          = src_ff - CNT_ONE;
               src_in          = src_ff + CNT_ONE;
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - CNT_ONE;
               done     = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = st;
         rsp_in.result_index = ridx;
         rsp_in.found        = fnd;
         busy_in             = 1'b0;
         state_in            = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
      end
      rsp_ff    <= rsp_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      unit_ff   <= unit_in;
      idx_ff    <= idx_in;
      in_use_ff <= in_use_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      hit_ff    <= hit_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SKT_ASSERT_IMPLY(a_rsp_not_busy, clock, reset, rsp_valid_ff, !busy_ff, "result while busy")
   `SKT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result repeated")
   `SKT_ASSERT_IMPLY(a_write_busy, clock, reset, mem_ctl.wr_en, busy_ff, "table write while idle")
   `SKT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff && !rsp_valid_ff, "accept not held")

endmodule

// File: hw/rtl/sorted_key_table_unit.sv
// Sorted key table: one command at a time, one result per command.
// Commands rejected at decode skip the search; a search makes up to log2(DEPTH)+1 probes,
// and add and remove shift the following entries one slot at a time.
// Busy stays high until the result cycle.
// The result strobe lasts one cycle and cannot be stalled; start is taken in that cycle.
// Synchronous reset empties the table and zeroes both registers; no clearing pass.
module sorted_key_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  skt_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output skt_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [skt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [skt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [skt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import skt_pkg::*;

   logic [CSR_DATA_W-1:0] null_key_ff, null_key_in;
   logic [CSR_DATA_W-1:0] mask_ff, mask_in;
   logic                  csr_write;
   cfg_type               cfg;
   mem_ctl_type           mem_ctl;
   logic [KEY_BITS-1:0]   key_wr_data, key_rd_data;
   logic [UNIT_BITS-1:0]  unit_wr_data, unit_rd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      null_key_in = null_key_ff;
      mask_in     = mask_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_NULL_KEY:      null_key_in = pwdata;
            REG_RESERVED_MASK: mask_in     = pwdata;
            default:           null_key_in = null_key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_key_ff <= '0;
         mask_ff     <= '0;
      end else begin
         null_key_ff <= null_key_in;
         mask_ff     <= mask_in;
      end
   end

   // misaligned reads return zero
   assign prdata = (paddr[1:0] != 2'b00) ? '0 :
                   (paddr[2] == REG_RESERVED_MASK) ? mask_ff : null_key_ff;

   assign cfg.null_key           = null_key_ff;
   assign cfg.reserved_flag_mask = mask_ff;

   skt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .cfg          (cfg),
      .mem_ctl      (mem_ctl),
      .key_wr_data  (key_wr_data),
      .unit_wr_data (unit_wr_data),
      .key_rd_data  (key_rd_data),
      .unit_rd_data (unit_rd_data)
   );

   skt_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (key_rd_data)
   );

   skt_ram #(
      .WIDTH (UNIT_BITS),
      .DEPTH (DEPTH)
   ) u_unit_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (unit_wr_data),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (unit_rd_data)
   );

endmodule
